// File: rtl/core/fn_layer_key_remapper_assert.svh
// Assertion macros used by the Fn layer key remapper result stage.
`ifndef FN_LAYER_KEY_REMAPPER_ASSERT_SVH
`define FN_LAYER_KEY_REMAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define FNKR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FNKR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FNKR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FNKR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/fnkr_pkg.sv
// Shared types and constants of the Fn layer key remapper.
`timescale 1ns / 1ps

package fnkr_pkg;

    // Matrix and map dimensions.
    localparam int KEY_COLUMNS = 32;
    localparam int KEY_ROWS    = 8;
    localparam int MAP_ENTRIES = 5;

    // Field widths.
    localparam int ROW_W      = 3;
    localparam int COL_W      = 5;
    localparam int CODE_W     = 16;
    localparam int COUNT_W    = 3;
    localparam int ENTRY_W    = 32;
    localparam int CFG_ADDR_W = 3;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    // Index widths into the down bitmap and the map.
    localparam int COL_IDX_W = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;
    localparam int ROW_IDX_W = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
    localparam int ENT_IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    // Command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FN_ROW    = 3'd0,
        CFG_FN_COL    = 3'd1,
        CFG_MAP_COUNT = 3'd2,
        CFG_MAP_0     = 3'd3,
        CFG_MAP_1     = 3'd4,
        CFG_MAP_2     = 3'd5,
        CFG_MAP_3     = 3'd6,
        CFG_MAP_4     = 3'd7
    } cfg_idx_t;

    // One classified command: a single result, or the Fn press/release pair.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              pressed;
        logic              has_override;
        logic [CODE_W-1:0] override_value;
        logic              fn_pair;
    } cmd_t;

endpackage

// File: rtl/core/fnkr_front.sv
// Front end: configuration registers, key state tracking and item classification.
`timescale 1ns / 1ps

module fnkr_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fnkr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fnkr_pkg::ENTRY_W-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fnkr_pkg::ROW_W-1:0]           key_row,
    input  logic [fnkr_pkg::COL_W-1:0]           key_col,
    input  logic                                 pressed,
    input  logic                                 q_full,
    output logic                                 q_push,
    output fnkr_pkg::cmd_t                       q_cmd
);
    import fnkr_pkg::*;

    // Configuration registers.
    logic [ROW_W-1:0]   fn_row_reg;
    logic [COL_W-1:0]   fn_col_reg;
    logic [COUNT_W-1:0] map_count_reg;
    logic [ENTRY_W-1:0] map_entry_reg [MAP_ENTRIES];

    // Layer state.
    logic                   fn_held_reg, fn_held_next;
    logic                   fn_used_reg, fn_used_next;
    logic [MAP_ENTRIES-1:0] mapped_down_reg, mapped_down_next;
    logic [KEY_ROWS-1:0]    kdm_reg [KEY_COLUMNS];
    logic [KEY_ROWS-1:0]    kdm_col_next;
    logic                   kdm_we;

    logic                   accept;
    logic [COUNT_W-1:0]     act_cnt;
    logic [MAP_ENTRIES-1:0] match;
    logic                   rel_found, prs_found;
    logic [ENT_IDX_W-1:0]   rel_idx, prs_idx;
    logic                   is_fn, in_matrix, kd_bit;
    logic [COL_IDX_W-1:0]   col_idx;
    logic [ROW_IDX_W-1:0]   row_idx;
    logic [CFG_ADDR_W-1:0]  ent_off;
    logic [ENT_IDX_W-1:0]   ent_wr_idx;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Configuration writes.
    assign ent_off    = cfg_addr - CFG_MAP_0;
    assign ent_wr_idx = ent_off[ENT_IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_row_reg    <= '0;
            fn_col_reg    <= '0;
            map_count_reg <= '0;
            for (int i = 0; i < MAP_ENTRIES; i++)
            begin
                map_entry_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FN_ROW:    fn_row_reg    <= cfg_data[ROW_W-1:0];
                CFG_FN_COL:    fn_col_reg    <= cfg_data[COL_W-1:0];
                CFG_MAP_COUNT: map_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_MAP_0, CFG_MAP_1, CFG_MAP_2, CFG_MAP_3, CFG_MAP_4:
                begin
                    if (int'(ent_off) < MAP_ENTRIES)
                    begin
                        map_entry_reg[ent_wr_idx] <= cfg_data;
                    end
                end
                default: ;
            endcase
        end
    end

    // Active entry count, clamped to the map size.
    assign act_cnt = (int'(map_count_reg) > MAP_ENTRIES) ? COUNT_W'(MAP_ENTRIES)
                                                         : map_count_reg;

    // Match every active entry against the key, full 8-bit fields.
    always_comb
    begin
        for (int i = 0; i < MAP_ENTRIES; i++)
        begin
            match[i] = (COUNT_W'(i) < act_cnt)
                    && (map_entry_reg[i][31:24] == 8'(key_row))
                    && (map_entry_reg[i][23:16] == 8'(key_col));
        end
    end

    // Lowest-numbered hit for a release (marked only) and for a press.
    always_comb
    begin
        rel_found = 1'b0;
        prs_found = 1'b0;
        rel_idx   = '0;
        prs_idx   = '0;
        for (int i = MAP_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i] && mapped_down_reg[i])
            begin
                rel_found = 1'b1;
                rel_idx   = ENT_IDX_W'(i);
            end
            if (match[i])
            begin
                prs_found = 1'b1;
                prs_idx   = ENT_IDX_W'(i);
            end
        end
    end

    // Down bitmap lookup for the key.
    assign in_matrix = (int'(key_row) < KEY_ROWS) && (int'(key_col) < KEY_COLUMNS);
    assign col_idx   = COL_IDX_W'(key_col);
    assign row_idx   = ROW_IDX_W'(key_row);
    assign kd_bit    = in_matrix && kdm_reg[col_idx][row_idx];
    assign is_fn     = (key_row == fn_row_reg) && (key_col == fn_col_reg);

    // Classification and next state.
    always_comb
    begin
        fn_held_next     = fn_held_reg;
        fn_used_next     = fn_used_reg;
        mapped_down_next = mapped_down_reg;
        kdm_col_next     = kdm_reg[col_idx];
        kdm_we           = 1'b0;
        q_push           = 1'b0;
        q_cmd.row            = key_row;
        q_cmd.col            = key_col;
        q_cmd.pressed        = pressed;
        q_cmd.has_override   = 1'b0;
        q_cmd.override_value = '0;
        q_cmd.fn_pair        = 1'b0;

        if (is_fn)
        begin
            fn_held_next = pressed;
            if (pressed)
            begin
                fn_used_next = 1'b0;
            end
            else if (!fn_used_reg)
            begin
                q_push        = accept;
                q_cmd.pressed = 1'b1;
                q_cmd.fn_pair = 1'b1;
            end
        end
        else if (!pressed)
        begin
            if (rel_found)
            begin
                mapped_down_next[rel_idx] = 1'b0;
                q_push                    = accept;
                q_cmd.has_override        = 1'b1;
                q_cmd.override_value      = map_entry_reg[rel_idx][CODE_W-1:0];
            end
            else if (kd_bit)
            begin
                kdm_col_next[row_idx] = 1'b0;
                kdm_we                = 1'b1;
                q_push                = accept;
            end
        end
        else if (fn_held_reg)
        begin
            fn_used_next = 1'b1;
            if (prs_found)
            begin
                mapped_down_next[prs_idx] = 1'b1;
                q_push                    = accept;
                q_cmd.has_override        = 1'b1;
                q_cmd.override_value      = map_entry_reg[prs_idx][CODE_W-1:0];
            end
        end
        else
        begin
            if (in_matrix)
            begin
                kdm_col_next[row_idx] = 1'b1;
                kdm_we                = 1'b1;
            end
            q_push = accept;
        end
    end

    // State registers, updated once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fn_held_reg     <= 1'b0;
            fn_used_reg     <= 1'b0;
            mapped_down_reg <= '0;
            for (int c = 0; c < KEY_COLUMNS; c++)
            begin
                kdm_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            fn_held_reg     <= fn_held_next;
            fn_used_reg     <= fn_used_next;
            mapped_down_reg <= mapped_down_next;
            if (kdm_we)
            begin
                kdm_reg[col_idx] <= kdm_col_next;
            end
        end
    end

endmodule

// File: rtl/core/fnkr_queue.sv
// Short command queue that decouples the front end from the result stage.
`timescale 1ns / 1ps

module fnkr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fnkr_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output fnkr_pkg::cmd_t pop_cmd
);
    import fnkr_pkg::*;

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/fnkr_back.sv
// Result stage: expands queued commands into result items behind an output register.
`timescale 1ns / 1ps

`include "fn_layer_key_remapper_assert.svh"

module fnkr_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_not_empty,
    input  fnkr_pkg::cmd_t                     q_cmd,
    output logic                               q_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fnkr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [fnkr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                               m_axis_tlast
);
    import fnkr_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic              pair_pending_reg, pair_pending_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic              out_pressed_reg, out_pressed_next;
    logic              out_has_reg, out_has_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              out_last_reg, out_last_next;
    logic              load_ok;

    // The output register may be loaded when empty or being taken.
    assign load_ok = !out_valid_reg || m_axis_tready;
    assign q_pop   = load_ok && !pair_pending_reg && q_not_empty;

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        pair_pending_next = pair_pending_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_pressed_next  = out_pressed_reg;
        out_has_next      = out_has_reg;
        out_code_next     = out_code_reg;
        out_last_next     = out_last_reg;
        if (load_ok)
        begin
            if (pair_pending_reg)
            begin
                // Second half of the Fn pair: release, closes the run.
                out_valid_next    = 1'b1;
                out_pressed_next  = 1'b0;
                out_last_next     = 1'b1;
                pair_pending_next = 1'b0;
            end
            else if (q_not_empty)
            begin
                out_valid_next    = 1'b1;
                out_row_next      = q_cmd.row;
                out_col_next      = q_cmd.col;
                out_pressed_next  = q_cmd.pressed;
                out_has_next      = q_cmd.has_override;
                out_code_next     = q_cmd.override_value;
                out_last_next     = !q_cmd.fn_pair;
                pair_pending_next = q_cmd.fn_pair;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            pair_pending_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg    <= out_valid_next;
            pair_pending_reg <= pair_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg     <= out_row_next;
        out_col_reg     <= out_col_next;
        out_pressed_reg <= out_pressed_next;
        out_has_reg     <= out_has_next;
        out_code_reg    <= out_code_next;
        out_last_reg    <= out_last_next;
    end

    // Output stream: tdata = out_row, out_col, override_value; tuser = out_pressed, has_override.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_code_reg, out_col_reg, out_row_reg};
    assign m_axis_tuser  = {out_has_reg, out_pressed_reg};
    assign m_axis_tlast  = out_last_reg;

    // A pending pair always sits behind its shown Fn press.
    `FNKR_ASSERT_IMP(a_pair_shows_press, clk, rst_n, pair_pending_reg, out_valid_reg && out_pressed_reg && !out_last_reg && !out_has_reg, "pending pair without a shown Fn press")
    // Taking the Fn press brings up the matching release next.
    `FNKR_ASSERT_NXT(a_pair_second_half, clk, rst_n, pair_pending_reg && m_axis_tready, out_valid_reg && !out_pressed_reg && out_last_reg && !pair_pending_reg, "Fn release did not follow its press")
    // No queue pop while the pair is still being emitted.
    `FNKR_ASSERT_IMP(a_no_pop_in_pair, clk, rst_n, pair_pending_reg, !q_pop, "queue popped during an Fn pair")
    // Without an override the code field is zero.
    `FNKR_ASSERT_IMP(a_code_zero, clk, rst_n, out_valid_reg && !out_has_reg, out_code_reg == '0, "override code set without override")

endmodule

// File: rtl/core/fn_layer_key_remapper.sv
// Path: an accepted input item is written into the command queue, and its result item
// is then loaded from the queue into the result stage's output register.
// Throughput: one input item per cycle while the command queue is not full; an untouched
// Fn release gives a press and a release item, emitted one per cycle while tready is high.
// Reset: rst_n is asynchronous, active low; clears configuration, Fn state, marks
// and the key down bitmap at once.
`timescale 1ns / 1ps

module fn_layer_key_remapper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fnkr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fnkr_pkg::ENTRY_W-1:0]        cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fnkr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // key_row, key_col
    input  logic [fnkr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // pressed
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fnkr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // out_row, out_col, override_value
    output logic [fnkr_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // out_pressed, has_override
    output logic                                m_axis_tlast   // last_of_run
);
    import fnkr_pkg::*;

    logic [ROW_W-1:0] key_row;
    logic [COL_W-1:0] key_col;
    logic             key_pressed;
    logic             q_full, q_push, q_pop, q_not_empty;
    cmd_t             push_cmd, pop_cmd;

    // Unpack the input item.
    assign key_row     = s_axis_tdata[ROW_W-1:0];
    assign key_col     = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign key_pressed = s_axis_tuser[0];

    // Front end: classification and state.
    fnkr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .key_row  (key_row),
        .key_col  (key_col),
        .pressed  (key_pressed),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // Command queue.
    fnkr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_cmd   (pop_cmd)
    );

    // Result stage.
    fnkr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_cmd         (pop_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: sim/tb_fn_layer_key_remapper.sv
// Self-checking testbench for the Fn layer key remapper with a built-in layer predictor.
`timescale 1ns / 1ps

module tb_fn_layer_key_remapper;
    import fnkr_pkg::*;

    // One key report as it leaves the block.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              pressed;
        logic              has_ovr;
        logic [CODE_W-1:0] code;
        logic              last;
    } key_report_t;

    // Ready patterns of the report sink.
    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PATTERN, RX_COIN} rx_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [ENTRY_W-1:0]     cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // key_row, key_col
    logic [IN_TUSER_W-1:0]  s_axis_tuser;   // pressed
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // out_row, out_col, override_value
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // out_pressed, has_override
    logic                   m_axis_tlast;   // last_of_run

    // Mirror of the layer registers.
    logic [ROW_W-1:0]   layer_fn_row;
    logic [COL_W-1:0]   layer_fn_col;
    logic [COUNT_W-1:0] layer_count;
    logic [ENTRY_W-1:0] layer_entry [MAP_ENTRIES];

    // Mirror of the key tracking state.
    logic                   fn_down;
    logic                   fn_touched;
    logic [MAP_ENTRIES-1:0] marks;
    logic [KEY_ROWS-1:0]    down_bits [KEY_COLUMNS];

    key_report_t expected_reports [$];
    int          fail_count = 0;
    int          burst_left = 0;
    logic [7:0]  sink_tick = '0;
    rx_mode_t    sink_mode = RX_OPEN;

    fn_layer_key_remapper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Queue one expected report.
    function automatic void push_report(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                                        input logic prs, input logic has,
                                        input logic [CODE_W-1:0] code, input logic last);
        key_report_t rep;
        rep.row     = row;
        rep.col     = col;
        rep.pressed = prs;
        rep.has_ovr = has;
        rep.code    = has ? code : '0;
        rep.last    = last;
        expected_reports.push_back(rep);
    endfunction

    // A map entry compares its full 8-bit row and column fields with the key.
    function automatic logic entry_hits(input int idx, input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
        return layer_entry[idx][31:24] == {5'b0, row} && layer_entry[idx][23:16] == {3'b0, col};
    endfunction

    // Apply the Fn layer to one accepted key event and queue its reports.
    function automatic void remap_key_event(input logic [ROW_W-1:0] row,
                                            input logic [COL_W-1:0] col, input logic prs);
        int   live;
        logic handled;
        live    = (layer_count > MAP_ENTRIES) ? MAP_ENTRIES : int'(layer_count);
        handled = 1'b0;
        if (row == layer_fn_row && col == layer_fn_col)
        begin
            fn_down = prs;
            if (prs)
                fn_touched = 1'b0;
            else if (!fn_touched)
            begin
                push_report(row, col, 1'b1, 1'b0, '0, 1'b0);
                push_report(row, col, 1'b0, 1'b0, '0, 1'b1);
            end
        end
        else if (!prs)
        begin
            // A marked mapped key releases with its code; otherwise use the bitmap.
            for (int i = 0; i < live && !handled; i++)
            begin
                if (entry_hits(i, row, col) && marks[i])
                begin
                    marks[i] = 1'b0;
                    push_report(row, col, 1'b0, 1'b1, layer_entry[i][15:0], 1'b1);
                    handled = 1'b1;
                end
            end
            if (!handled && down_bits[col][row])
            begin
                down_bits[col][row] = 1'b0;
                push_report(row, col, 1'b0, 1'b0, '0, 1'b1);
            end
        end
        else if (fn_down)
        begin
            // Under Fn only mapped keys get through; the lowest entry wins.
            fn_touched = 1'b1;
            for (int i = 0; i < live && !handled; i++)
            begin
                if (entry_hits(i, row, col))
                begin
                    marks[i] = 1'b1;
                    push_report(row, col, 1'b1, 1'b1, layer_entry[i][15:0], 1'b1);
                    handled = 1'b1;
                end
            end
        end
        else
        begin
            down_bits[col][row] = 1'b1;
            push_report(row, col, 1'b1, 1'b0, '0, 1'b1);
        end
    endfunction

    function automatic logic [ENTRY_W-1:0] make_entry(input logic [7:0] row, input logic [7:0] col,
                                                      input logic [CODE_W-1:0] code);
        return {row, col, code};
    endfunction

    // Mostly entries inside the matrix, now and then an over-wide row or column.
    function automatic logic [ENTRY_W-1:0] rand_entry();
        logic [7:0] row;
        logic [7:0] col;
        row = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, 255)) : 8'($urandom_range(0, 7));
        col = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(32, 255)) : 8'($urandom_range(0, 31));
        return make_entry(row, col, 16'($urandom));
    endfunction

    function automatic void note_mismatch(input string what, input key_report_t want,
                                          input key_report_t seen);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s: expected row=%0d col=%0d prs=%0b ovr=%0b code=%h last=%0b", $realtime,
                     what, want.row, want.col, want.pressed, want.has_ovr, want.code, want.last);
            $display("%0t: %s: actual   row=%0d col=%0d prs=%0b ovr=%0b code=%h last=%0b", $realtime,
                     what, seen.row, seen.col, seen.pressed, seen.has_ovr, seen.code, seen.last);
        end
    endfunction

    // Compare every report the sink takes with the oldest expectation.
    always @(posedge clk)
    begin : check_reports
        key_report_t seen;
        key_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.row     = m_axis_tdata[2:0];
            seen.col     = m_axis_tdata[7:3];
            seen.code    = m_axis_tdata[23:8];
            seen.pressed = m_axis_tuser[0];
            seen.has_ovr = m_axis_tuser[1];
            seen.last    = m_axis_tlast;
            if (expected_reports.size() == 0)
                note_mismatch("report with nothing expected", '0, seen);
            else
            begin
                want = expected_reports.pop_front();
                if (seen.row !== want.row || seen.col !== want.col ||
                    seen.pressed !== want.pressed || seen.has_ovr !== want.has_ovr ||
                    seen.code !== want.code || seen.last !== want.last)
                    note_mismatch("report mismatch", want, seen);
            end
        end
    end

    // Sink ready: a new pattern whenever the low six bits of sink_tick are zero.
    always @(posedge clk)
    begin
        sink_tick <= sink_tick + 8'd1;
        if (sink_tick[5:0] == 6'd0)
            sink_mode <= rx_mode_t'($urandom_range(0, 3));
        case (sink_mode)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
            RX_PATTERN: m_axis_tready <= (sink_tick[2:0] < 3'd3);
            default:    m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Send one key event in bursts separated by random gaps.
    task automatic send_event(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic prs);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {col, row};
        s_axis_tuser  <= prs;
        do
            @(posedge clk);
        while (!s_axis_tready);
        remap_key_event(row, col, prs);
    endtask

    // Stop sending and let all outstanding reports drain, including dropped events.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write every layer register once the block is idle.
    task automatic program_layer(input logic [ROW_W-1:0] fn_row, input logic [COL_W-1:0] fn_col,
                                 input logic [COUNT_W-1:0] count,
                                 input logic [MAP_ENTRIES-1:0][ENTRY_W-1:0] ents);
        settle();
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_FN_ROW;
        cfg_data <= ENTRY_W'(fn_row);
        @(posedge clk);
        cfg_addr <= CFG_FN_COL;
        cfg_data <= ENTRY_W'(fn_col);
        @(posedge clk);
        cfg_addr <= CFG_MAP_COUNT;
        cfg_data <= ENTRY_W'(count);
        @(posedge clk);
        for (int i = 0; i < MAP_ENTRIES; i++)
        begin
            cfg_addr <= cfg_idx_t'(CFG_MAP_0 + i);
            cfg_data <= ents[i];
            @(posedge clk);
            layer_entry[i] = ents[i];
        end
        cfg_we <= 1'b0;
        layer_fn_row = fn_row;
        layer_fn_col = fn_col;
        layer_count  = count;
    endtask

    // Reset layout: Fn at row 0 column 0 and an empty map.
    task automatic test_default_layer();
        send_event(3'd0, 5'd0, 1'b1);
        send_event(3'd0, 5'd0, 1'b0);
        send_event(3'd0, 5'd0, 1'b0);   // Fn release with no press: the pair again
        send_event(3'd7, 5'd31, 1'b0);  // release never sent
        send_event(3'd7, 5'd31, 1'b1);
        send_event(3'd7, 5'd31, 1'b0);
        send_event(3'd5, 5'd10, 1'b1);
        send_event(3'd5, 5'd10, 1'b0);
    endtask

    // Fn layer with duplicate, over-wide and uncounted entries.
    task automatic test_fn_layer();
        program_layer(3'd3, 5'd17, 3'd3,
                      {make_entry(8'd2, 8'd40, 16'h7777), make_entry(8'd4, 8'd31, 16'hFFFF),
                       make_entry(8'd9, 8'd2, 16'h5555), make_entry(8'd1, 8'd2, 16'h1111),
                       make_entry(8'd1, 8'd2, 16'hABCD)});
        send_event(3'd3, 5'd17, 1'b1);
        send_event(3'd1, 5'd2, 1'b1);   // first of two matching entries
        send_event(3'd6, 5'd6, 1'b1);   // unmapped under Fn: dropped
        send_event(3'd4, 5'd31, 1'b1);  // entry past the count: dropped
        send_event(3'd1, 5'd2, 1'b0);
        send_event(3'd1, 5'd2, 1'b0);
        send_event(3'd3, 5'd17, 1'b0);  // Fn was used: silent
        send_event(3'd3, 5'd17, 1'b1);
        send_event(3'd3, 5'd17, 1'b0);
        send_event(3'd1, 5'd2, 1'b1);
        send_event(3'd1, 5'd2, 1'b0);
        send_event(3'd6, 5'd6, 1'b0);
    endtask

    // A mark set with an oversized count survives while the count hides it.
    task automatic test_stale_marks();
        logic [MAP_ENTRIES-1:0][ENTRY_W-1:0] ents;
        ents = {make_entry(8'd0, 8'd0, 16'h0000), make_entry(8'd4, 8'd31, 16'hFFFF),
                make_entry(8'd255, 8'd255, 16'hFFFF), make_entry(8'd0, 8'd9, 16'h0001),
                make_entry(8'd7, 8'd0, 16'h8000)};
        program_layer(3'd3, 5'd17, 3'd7, ents);
        send_event(3'd3, 5'd17, 1'b1);
        send_event(3'd4, 5'd31, 1'b1);
        send_event(3'd3, 5'd17, 1'b0);
        program_layer(3'd3, 5'd17, 3'd0, ents);
        send_event(3'd4, 5'd31, 1'b0);  // mark hidden, no bitmap bit: dropped
        program_layer(3'd3, 5'd17, 3'd5, ents);
        send_event(3'd4, 5'd31, 1'b0);  // mark visible again
    endtask

    // Random key traffic on a small key set so that Fn and map sequences complete.
    task automatic random_traffic(input int n);
        logic [ROW_W-1:0] pool_row [6];
        logic [COL_W-1:0] pool_col [6];
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        int               pick;
        int               k;
        for (int i = 0; i < 6; i++)
        begin
            pool_row[i] = 3'($urandom);
            pool_col[i] = 5'($urandom);
        end
        for (int j = 0; j < n; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                row = layer_fn_row;
                col = layer_fn_col;
            end
            else if (pick < 50)
            begin
                k   = $urandom_range(0, MAP_ENTRIES - 1);
                row = layer_entry[k][26:24];
                col = layer_entry[k][20:16];
            end
            else if (pick < 85)
            begin
                k   = $urandom_range(0, 5);
                row = pool_row[k];
                col = pool_col[k];
            end
            else
            begin
                row = 3'($urandom);
                col = 5'($urandom);
            end
            send_event(row, col, 1'($urandom_range(0, 1)));
        end
    endtask

    // Several layer settings, extremes among them, each with a random stretch.
    task automatic test_random_layers();
        logic [MAP_ENTRIES-1:0][ENTRY_W-1:0] ents;
        for (int i = 0; i < MAP_ENTRIES; i++)
            ents[i] = make_entry(8'($urandom_range(0, 7)), 8'($urandom_range(0, 31)), 16'($urandom));
        program_layer(3'd7, 5'd31, 3'd5, ents);
        random_traffic(85);

        for (int i = 0; i < MAP_ENTRIES; i++)
            ents[i] = rand_entry();
        program_layer(3'd0, 5'd0, 3'd0, ents);
        random_traffic(85);

        for (int i = 0; i < MAP_ENTRIES; i++)
            ents[i] = rand_entry();
        ents[2] = {ents[0][31:16], 16'($urandom)};
        program_layer(3'($urandom), 5'($urandom), 3'd7, ents);
        random_traffic(85);

        for (int i = 0; i < MAP_ENTRIES; i++)
            ents[i] = rand_entry();
        program_layer(3'($urandom), 5'($urandom), 3'($urandom_range(1, 4)), ents);
        random_traffic(85);

        for (int i = 0; i < MAP_ENTRIES; i++)
            ents[i] = rand_entry();
        ents[1] = 32'hFFFF_FFFF;
        ents[3] = make_entry(8'd0, 8'd0, 16'hFFFF);
        program_layer(3'($urandom), 5'($urandom), 3'd6, ents);
        random_traffic(85);
    endtask

    // Main sequence.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        layer_fn_row  = '0;
        layer_fn_col  = '0;
        layer_count   = '0;
        fn_down       = 1'b0;
        fn_touched    = 1'b0;
        marks         = '0;
        for (int i = 0; i < MAP_ENTRIES; i++)
            layer_entry[i] = '0;
        for (int i = 0; i < KEY_COLUMNS; i++)
            down_bits[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_layer();
        test_fn_layer();
        test_stale_marks();
        test_random_layers();

        settle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("tb_fn_layer_key_remapper: clean");
        else
            $display("tb_fn_layer_key_remapper: errors");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("tb_fn_layer_key_remapper: errors");
        $finish;
    end

endmodule
